// ===== src/fepc_pkg.sv =====
// Package for the fixed-event performance counter unit: sizes, register map
// offsets, action codes and the counter read helper.
// Depends on nothing; used by src/fixed_event_perf_counter_unit.sv.
package fepc_pkg;

  localparam int N_CNT         = 8;
  localparam int COUNTER_WIDTH = 32;

  localparam int OFF_W  = 15;
  localparam int DATA_W = 32;
  localparam int HITS_W = 8;
  localparam int ACT_W  = 2;

  // Input tdata: reg_offset, write_value, event_hits; padded to whole bytes.
  localparam int IN_RAW_W  = OFF_W + DATA_W + HITS_W;
  localparam int IN_DATA_W = ((IN_RAW_W + 7) / 8) * 8;
  // Output tdata: read_value, irq; padded to whole bytes.
  localparam int OUT_RAW_W  = DATA_W + 1;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  typedef logic [COUNTER_WIDTH-1:0] cnt_t;
  typedef logic [N_CNT-1:0]         bits_t;
  typedef logic [OFF_W-1:0]         off_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2
  } action_e;

  localparam off_t OFF_CTRL       = 15'h4930;
  localparam off_t OFF_EVENT_EN   = 15'h4d60;
  localparam off_t OFF_INT_MASK   = 15'h06c8;
  localparam off_t OFF_INT_STATUS = 15'h06cc;
  localparam off_t OFF_INT_CLEAR  = 15'h06d0;

  localparam int CTRL_EN_BIT = 0;

  localparam off_t CNT_OFF [8] = '{
    15'h4948, 15'h494c, 15'h4950, 15'h4954,
    15'h4984, 15'h4988, 15'h4990, 15'h4994
  };

  // Low data word of a counter, zero-extended when the counter is narrower.
  function automatic logic [DATA_W-1:0] counter_low(cnt_t c);
    logic [63:0] wide;
    wide = 64'(c);
    return wide[DATA_W-1:0];
  endfunction

endpackage

// ===== src/fixed_event_perf_counter_unit.sv =====
// Top level of the fixed-event performance counter unit: input register,
// register map and counter update, result register.
// Depends on src/fepc_pkg.sv.
//
// An accepted item waits in the input register until the result register is
// free or being drained, then moves into it. Throughput: one item per cycle
// unless the result output stalls; the counter increment, wrap check and
// register read mux form the single path between input and result register.
// Reset: rst_ni clears all counters, enable bits and status, sets every
// interrupt mask bit, and empties both pipeline registers.
module fixed_event_perf_counter_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Item in
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [14:0] reg_offset, [46:15] write_value, [54:47] event_hits, [55] zero
  input  logic [fepc_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // [1:0] action
  input  logic [fepc_pkg::ACT_W-1:0]      s_axis_tuser_i,
  // Result out
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [31:0] read_value, [32] irq, [39:33] zero
  output logic [fepc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  // Input register
  logic                           in_vld_q, in_vld_d;
  logic [fepc_pkg::IN_DATA_W-1:0] in_data_q;
  logic [fepc_pkg::ACT_W-1:0]     in_user_q;

  // Result register
  logic                            out_vld_q, out_vld_d;
  logic [fepc_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;

  // Block state
  fepc_pkg::cnt_t  cnt_q [fepc_pkg::N_CNT];
  fepc_pkg::cnt_t  cnt_d [fepc_pkg::N_CNT];
  logic            cnt_en_q, cnt_en_d;
  fepc_pkg::bits_t ev_en_q, ev_en_d;
  fepc_pkg::bits_t mask_q, mask_d;
  fepc_pkg::bits_t ovf_q, ovf_d;

  logic s_accept;
  logic advance;

  // Fields of the item held in the input register
  fepc_pkg::action_e         act;
  fepc_pkg::off_t            off;
  logic [fepc_pkg::DATA_W-1:0] wval;
  fepc_pkg::bits_t           hits;
  logic [fepc_pkg::DATA_W-1:0] rd_val;
  logic                      irq;

  // Move an item on whenever the result register is free or being drained.
  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  assign act  = fepc_pkg::action_e'(in_user_q);
  assign off  = in_data_q[fepc_pkg::OFF_W-1:0];
  assign wval = in_data_q[fepc_pkg::OFF_W +: fepc_pkg::DATA_W];
  assign hits = in_data_q[fepc_pkg::OFF_W + fepc_pkg::DATA_W +: fepc_pkg::N_CNT];

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  // Register map and counter update for the held item.
  always_comb begin
    cnt_d    = cnt_q;
    cnt_en_d = cnt_en_q;
    ev_en_d  = ev_en_q;
    mask_d   = mask_q;
    ovf_d    = ovf_q;
    rd_val   = '0;

    unique case (act)
      fepc_pkg::ACT_TICK: begin
        if (cnt_en_q) begin
          for (int i = 0; i < fepc_pkg::N_CNT; i++) begin
            if (ev_en_q[i] && hits[i]) begin
              cnt_d[i] = cnt_q[i] + fepc_pkg::cnt_t'(1);
              // Wrap to zero flags overflow
              if (cnt_d[i] == '0) begin
                ovf_d[i] = 1'b1;
              end
            end
          end
        end
      end
      fepc_pkg::ACT_READ: begin
        unique case (off)
          fepc_pkg::OFF_CTRL:       rd_val = fepc_pkg::DATA_W'(cnt_en_q);
          fepc_pkg::OFF_EVENT_EN:   rd_val = fepc_pkg::DATA_W'(ev_en_q);
          fepc_pkg::OFF_INT_MASK:   rd_val = fepc_pkg::DATA_W'(mask_q);
          fepc_pkg::OFF_INT_STATUS: rd_val = fepc_pkg::DATA_W'(ovf_q);
          default: begin
            for (int i = 0; i < fepc_pkg::N_CNT; i++) begin
              if (off == fepc_pkg::CNT_OFF[i]) begin
                rd_val = fepc_pkg::counter_low(cnt_q[i]);
              end
            end
          end
        endcase
      end
      fepc_pkg::ACT_WRITE: begin
        // Counters and status are read-only; drop writes to them.
        unique case (off)
          fepc_pkg::OFF_CTRL:      cnt_en_d = wval[fepc_pkg::CTRL_EN_BIT];
          fepc_pkg::OFF_EVENT_EN:  ev_en_d  = wval[fepc_pkg::N_CNT-1:0];
          fepc_pkg::OFF_INT_MASK:  mask_d   = wval[fepc_pkg::N_CNT-1:0];
          fepc_pkg::OFF_INT_CLEAR: ovf_d    = ovf_q & ~wval[fepc_pkg::N_CNT-1:0];
          default: ;
        endcase
      end
      default: ;
    endcase

    // Interrupt reflects the state after this item.
    irq = |(ovf_d & ~mask_d);
  end

  always_comb begin
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    if (advance) begin
      out_vld_d  = 1'b1;
      out_data_d = fepc_pkg::OUT_DATA_W'({irq, rd_val});
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  // Control and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cnt_en_q  <= 1'b0;
      ev_en_q   <= '0;
      mask_q    <= '1;
      ovf_q     <= '0;
      for (int i = 0; i < fepc_pkg::N_CNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) begin
        cnt_en_q <= cnt_en_d;
        ev_en_q  <= ev_en_d;
        mask_q   <= mask_d;
        ovf_q    <= ovf_d;
        cnt_q    <= cnt_d;
      end
    end
  end

  // Payload registers: hold unless loading
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_data_q <= s_axis_tdata_i;
      in_user_q <= s_axis_tuser_i;
    end
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== tb/sv/fixed_event_perf_counter_unit_tb.sv =====
// Self-checking testbench for the fixed-event performance counter unit: a directed table,
// then random items of every action, checked against a shadow copy of the register map.
// Depends on src/fepc_pkg.sv and src/fixed_event_perf_counter_unit.sv.
module fixed_event_perf_counter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Action code that the block must treat as a no-op
  localparam logic [fepc_pkg::ACT_W-1:0] ACT_RSVD = 2'd3;
  localparam int RAND_ITEMS   = 425;
  localparam int MAX_WAIT     = 17;
  localparam int DRAIN_CYCLES = 8;
  localparam int PLAN_LEN     = 25;

  typedef struct packed {
    logic [fepc_pkg::DATA_W-1:0] read_value;
    logic                        irq;
  } pmu_result_t;

  typedef struct {
    logic [fepc_pkg::ACT_W-1:0]  act;
    fepc_pkg::off_t              off;
    logic [fepc_pkg::DATA_W-1:0] wval;
    fepc_pkg::bits_t             hits;
    bit                          typed;  // 1: rd below is the expected read_value
    logic [fepc_pkg::DATA_W-1:0] rd;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_tvalid;
  logic s_axis_tready_o;
  logic [fepc_pkg::IN_DATA_W-1:0] s_tdata;
  logic [fepc_pkg::ACT_W-1:0] s_tuser;
  logic m_axis_tvalid_o;
  logic m_tready;
  logic [fepc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;

  // Shadow copy of the block's state, updated as items are accepted
  fepc_pkg::cnt_t  shadow_count [fepc_pkg::N_CNT];
  logic            shadow_run;
  fepc_pkg::bits_t shadow_evt_en;
  fepc_pkg::bits_t shadow_mask;
  fepc_pkg::bits_t shadow_ovf;

  // Results owed by the block, oldest first
  pmu_result_t pending_results[$];

  bit send_calm;
  bit recv_calm;
  int err_cnt;
  int n_ticks;
  int n_reads;
  int n_writes;
  int n_rsvd;
  int n_results;

  // Directed rows: reset values, write masking, ignored writes, unaligned and
  // unmapped offsets, the reserved action. Counter values come from the shadow.
  plan_row_t plan [PLAN_LEN] = '{
    '{fepc_pkg::ACT_READ,  fepc_pkg::OFF_CTRL,       '0, '0, 1'b1, 32'h0},
    '{fepc_pkg::ACT_READ,  fepc_pkg::OFF_EVENT_EN,   '0, '0, 1'b1, 32'h0},
    '{fepc_pkg::ACT_READ,  fepc_pkg::OFF_INT_MASK,   '0, '0, 1'b1, 32'hff},
    '{fepc_pkg::ACT_READ,  fepc_pkg::OFF_INT_STATUS, '0, '0, 1'b1, 32'h0},
    '{fepc_pkg::ACT_READ,  fepc_pkg::OFF_INT_CLEAR,  '0, '0, 1'b1, 32'h0},
    '{fepc_pkg::ACT_READ,  fepc_pkg::CNT_OFF[0],     '0, '0, 1'b1, 32'h0},
    '{fepc_pkg::ACT_READ,  fepc_pkg::CNT_OFF[7],     '0, '0, 1'b1, 32'h0},
    '{fepc_pkg::ACT_READ,  15'h7fff,                 '0, '0, 1'b1, 32'h0},
    '{fepc_pkg::ACT_TICK,  fepc_pkg::OFF_CTRL,       '0, 8'hff, 1'b0, 32'h0},
    '{fepc_pkg::ACT_WRITE, fepc_pkg::OFF_CTRL,       32'hffff_ffff, '0, 1'b1, 32'h0},
    '{fepc_pkg::ACT_READ,  fepc_pkg::OFF_CTRL,       '0, '0, 1'b1, 32'h1},
    '{fepc_pkg::ACT_WRITE, fepc_pkg::OFF_EVENT_EN,   32'hffff_ffff, '0, 1'b1, 32'h0},
    '{fepc_pkg::ACT_READ,  fepc_pkg::OFF_EVENT_EN,   '0, '0, 1'b1, 32'hff},
    '{fepc_pkg::ACT_TICK,  fepc_pkg::OFF_CTRL,       '0, 8'hff, 1'b0, 32'h0},
    '{fepc_pkg::ACT_TICK,  fepc_pkg::OFF_CTRL,       '0, 8'h00, 1'b0, 32'h0},
    '{fepc_pkg::ACT_TICK,  fepc_pkg::OFF_CTRL,       '0, 8'ha5, 1'b0, 32'h0},
    '{fepc_pkg::ACT_READ,  fepc_pkg::CNT_OFF[0],     '0, '0, 1'b0, 32'h0},
    '{fepc_pkg::ACT_READ,  fepc_pkg::CNT_OFF[5],     '0, '0, 1'b0, 32'h0},
    '{fepc_pkg::ACT_WRITE, fepc_pkg::CNT_OFF[0],     32'h1234_5678, '0, 1'b0, 32'h0},
    '{fepc_pkg::ACT_WRITE, fepc_pkg::OFF_INT_STATUS, 32'hffff_ffff, '0, 1'b0, 32'h0},
    '{fepc_pkg::ACT_WRITE, fepc_pkg::OFF_INT_MASK,   32'h0, '0, 1'b0, 32'h0},
    '{fepc_pkg::ACT_WRITE, fepc_pkg::OFF_INT_CLEAR,  32'hffff_ffff, '0, 1'b0, 32'h0},
    '{fepc_pkg::ACT_READ,  fepc_pkg::OFF_CTRL + 15'd1, '0, '0, 1'b1, 32'h0},
    '{ACT_RSVD,            fepc_pkg::OFF_CTRL,       32'hffff_ffff, 8'hff, 1'b1, 32'h0},
    '{fepc_pkg::ACT_READ,  fepc_pkg::CNT_OFF[0],     '0, '0, 1'b0, 32'h0}
  };

  fixed_event_perf_counter_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #1 clk_i = ~clk_i;

  // Apply one accepted item to the shadow state and return what the block owes.
  function automatic pmu_result_t predict_pmu(logic [fepc_pkg::ACT_W-1:0] act,
                                              fepc_pkg::off_t off,
                                              logic [fepc_pkg::DATA_W-1:0] wval,
                                              fepc_pkg::bits_t hits);
    pmu_result_t res;
    int i;
    res.read_value = '0;
    case (act)
      fepc_pkg::ACT_TICK: begin
        // Count only while globally enabled; wrap to zero flags overflow
        if (shadow_run) begin
          for (i = 0; i < fepc_pkg::N_CNT; i++) begin
            if (shadow_evt_en[i] && hits[i]) begin
              shadow_count[i] = shadow_count[i] + 1'b1;
              if (shadow_count[i] == '0) shadow_ovf[i] = 1'b1;
            end
          end
        end
      end
      fepc_pkg::ACT_READ: begin
        if (off == fepc_pkg::OFF_CTRL)
          res.read_value = fepc_pkg::DATA_W'(shadow_run);
        else if (off == fepc_pkg::OFF_EVENT_EN)
          res.read_value = fepc_pkg::DATA_W'(shadow_evt_en);
        else if (off == fepc_pkg::OFF_INT_MASK)
          res.read_value = fepc_pkg::DATA_W'(shadow_mask);
        else if (off == fepc_pkg::OFF_INT_STATUS)
          res.read_value = fepc_pkg::DATA_W'(shadow_ovf);
        else begin
          for (i = 0; i < fepc_pkg::N_CNT; i++)
            if (off == fepc_pkg::CNT_OFF[i])
              res.read_value = fepc_pkg::DATA_W'(shadow_count[i]);
        end
      end
      fepc_pkg::ACT_WRITE: begin
        // Counters and status are read-only; anything else unmapped drops the write
        case (off)
          fepc_pkg::OFF_CTRL:      shadow_run = wval[fepc_pkg::CTRL_EN_BIT];
          fepc_pkg::OFF_EVENT_EN:  shadow_evt_en = wval[fepc_pkg::N_CNT-1:0];
          fepc_pkg::OFF_INT_MASK:  shadow_mask = wval[fepc_pkg::N_CNT-1:0];
          fepc_pkg::OFF_INT_CLEAR: shadow_ovf = shadow_ovf & ~wval[fepc_pkg::N_CNT-1:0];
          default: ;
        endcase
      end
      default: ;
    endcase
    res.irq = |(shadow_ovf & ~shadow_mask);
    return res;
  endfunction

  // Present one item after a random gap unless send_calm, hold it until accepted,
  // then record what the block owes for it. Returns at the accepting clock edge.
  task automatic push_item(input logic [fepc_pkg::ACT_W-1:0] act,
                           input fepc_pkg::off_t off,
                           input logic [fepc_pkg::DATA_W-1:0] wval,
                           input fepc_pkg::bits_t hits,
                           input bit typed,
                           input logic [fepc_pkg::DATA_W-1:0] typed_rd);
    int gap;
    pmu_result_t pred;
    gap = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= fepc_pkg::IN_DATA_W'({hits, wval, off});
    do @(posedge clk_i); while (!s_axis_tready_o);
    pred = predict_pmu(act, off, wval, hits);
    // Typed rows carry their own read value; irq there is always clear
    if (typed) pending_results.push_back(pmu_result_t'{typed_rd, 1'b0});
    else pending_results.push_back(pred);
    case (act)
      fepc_pkg::ACT_TICK:  n_ticks++;
      fepc_pkg::ACT_READ:  n_reads++;
      fepc_pkg::ACT_WRITE: n_writes++;
      default:             n_rsvd++;
    endcase
  endtask

  // Drop valid and hold off until the block has delivered every owed result.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Item source: reset, directed table, random traffic, drain, verdict.
  initial begin
    int n;
    int sel;
    logic [fepc_pkg::ACT_W-1:0] act;
    fepc_pkg::off_t off;
    logic [fepc_pkg::DATA_W-1:0] wval;
    fepc_pkg::bits_t hits;

    rst_ni   = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = fepc_pkg::ACT_TICK;
    for (n = 0; n < fepc_pkg::N_CNT; n++) shadow_count[n] = '0;
    shadow_run    = 1'b0;
    shadow_evt_en = '0;
    shadow_mask   = '1;
    shadow_ovf    = '0;
    send_calm     = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < PLAN_LEN; n++) begin
      if (n == 12) send_calm = 1'b1;
      push_item(plan[n].act, plan[n].off, plan[n].wval, plan[n].hits,
                plan[n].typed, plan[n].rd);
    end

    for (n = 0; n < RAND_ITEMS; n++) begin
      // Switch between bursty and back-to-back stretches
      if (n % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
      // Once mid-run, let the pipeline empty completely
      if (n == RAND_ITEMS / 2) wait_for_results();

      sel = $urandom_range(0, 99);
      if (sel < 45) act = fepc_pkg::ACT_TICK;
      else if (sel < 75) act = fepc_pkg::ACT_READ;
      else if (sel < 95) act = fepc_pkg::ACT_WRITE;
      else act = ACT_RSVD;

      // Mostly mapped offsets, some just off alignment, some anywhere
      sel = $urandom_range(0, 19);
      case (sel)
        8:  off = fepc_pkg::OFF_CTRL;
        9:  off = fepc_pkg::OFF_EVENT_EN;
        10: off = fepc_pkg::OFF_INT_MASK;
        11: off = fepc_pkg::OFF_INT_STATUS;
        12: off = fepc_pkg::OFF_INT_CLEAR;
        13, 14, 15: off = fepc_pkg::CNT_OFF[$urandom_range(0, 7)]
                          + fepc_pkg::OFF_W'($urandom_range(1, 3));
        default: begin
          if (sel < 8) off = fepc_pkg::CNT_OFF[sel];
          else off = fepc_pkg::OFF_W'($urandom);
        end
      endcase

      wval = $urandom;
      // Keep counting switched on most of the time so counters advance
      if (act == fepc_pkg::ACT_WRITE && off == fepc_pkg::OFF_CTRL &&
          $urandom_range(0, 3) != 0)
        wval[fepc_pkg::CTRL_EN_BIT] = 1'b1;
      hits = ($urandom_range(0, 3) == 0) ? '1 : fepc_pkg::HITS_W'($urandom);

      push_item(act, off, wval, hits, 1'b0, '0);
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d items: %0d ticks, %0d reads, %0d writes, %0d reserved actions.",
             n_ticks + n_reads + n_writes + n_rsvd, n_ticks, n_reads, n_writes, n_rsvd);
    $display("Compared %0d results with the shadow register map; %0d mismatches.",
             n_results, err_cnt);
    if (err_cnt == 0) begin
      $display("fixed_event_perf_counter_unit_tb passed");
    end else begin
      $display("fixed_event_perf_counter_unit_tb failed");
    end
    $finish;
  end

  // Result sink: stall at random unless recv_calm, take each result and check it
  // against the oldest owed one.
  initial begin
    int stall;
    logic [fepc_pkg::DATA_W-1:0] got_rd;
    logic got_irq;
    pmu_result_t want;

    m_tready  = 1'b0;
    recv_calm = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = recv_calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      got_rd  = m_axis_tdata_o[fepc_pkg::DATA_W-1:0];
      got_irq = m_axis_tdata_o[fepc_pkg::DATA_W];
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result read_value=%h irq=%b", $time, got_rd, got_irq);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (got_rd !== want.read_value) begin
          $display("%0t: read_value mismatch: expected %h, got %h",
                   $time, want.read_value, got_rd);
          err_cnt++;
        end
        if (got_irq !== want.irq) begin
          $display("%0t: irq mismatch: expected %b, got %b", $time, want.irq, got_irq);
          err_cnt++;
        end
      end
      if (n_results % 50 == 0) recv_calm = ($urandom_range(0, 3) == 0);
    end
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #400000;
    $display("Timed out with %0d results still owed.", pending_results.size());
    $display("fixed_event_perf_counter_unit_tb failed");
    $finish;
  end

endmodule

// ===== fixed_event_perf_counter_unit.f =====
src/fepc_pkg.sv
src/fixed_event_perf_counter_unit.sv
tb/sv/fixed_event_perf_counter_unit_tb.sv
